### sv/pca_pkg.sv
// Package for the palette color adjust block: mode and register codes,
// reset values and the per-channel configuration type.
// No dependencies.
`default_nettype none

package pca_pkg;

    // Default depth of the save buffer
    localparam int PCA_SAVE_DEPTH = 256;

    // Mode register codes
    localparam logic [2:0] MODE_SCALE   = 3'd0;
    localparam logic [2:0] MODE_OFFSET  = 3'd1;
    localparam logic [2:0] MODE_FILL    = 3'd2;
    localparam logic [2:0] MODE_SAVE    = 3'd3;
    localparam logic [2:0] MODE_RESTORE = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE         = 3'd0;
    localparam logic [2:0] CFG_SCALE_FACTOR = 3'd1;
    localparam logic [2:0] CFG_RED_OFFSET   = 3'd2;
    localparam logic [2:0] CFG_GREEN_OFFSET = 3'd3;
    localparam logic [2:0] CFG_BLUE_OFFSET  = 3'd4;
    localparam logic [2:0] CFG_FILL_RED     = 3'd5;
    localparam logic [2:0] CFG_FILL_GREEN   = 3'd6;
    localparam logic [2:0] CFG_FILL_BLUE    = 3'd7;

    // Reset value of the scale factor (unity after the shift by 7)
    localparam logic [15:0] SCALE_RESET = 16'd128;

    // Scale product saturation limit and channel maximum
    localparam logic [23:0] SAT_LIMIT = 24'h007FFF;
    localparam logic [7:0]  CHAN_MAX  = 8'hFF;

    // Settings seen by one color channel
    typedef struct packed {
        logic [2:0]        mode;
        logic [15:0]       scale;
        logic signed [8:0] offset;
        logic [7:0]        fill;
    } t_chan_cfg;

endpackage

`default_nettype wire

### sv/pca_save_mem.sv
// Save buffer of the palette color adjust block: one write port and one
// read port, synchronous, read data registered.
// Depends on nothing but its parameters.
`default_nettype none

module pca_save_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/pca_chan_alu.sv
// One color channel of the palette color adjust block: scale with
// saturation, signed offset with clamp, or fill; else passes the channel through. Uses pca_pkg.
`default_nettype none

module pca_chan_alu (
    input  wire logic               i_en,
    input  wire logic [7:0]         i_chan,
    input  wire pca_pkg::t_chan_cfg i_cfg,
    output logic      [7:0]         o_chan
);
    import pca_pkg::*;

    logic [23:0]       prod;
    logic [23:0]       prod_sat;
    logic signed [9:0] sum;

    // 8x16 product, saturated, then shifted down by 7
    assign prod     = {16'd0, i_chan} * {8'd0, i_cfg.scale};
    assign prod_sat = (prod > SAT_LIMIT) ? SAT_LIMIT : prod;

    // Exact signed sum of channel and delta
    assign sum = $signed({2'b00, i_chan}) + 10'(i_cfg.offset);

    always_comb begin
        o_chan = i_chan;
        if (i_en) begin
            case (i_cfg.mode)
                MODE_SCALE: begin
                    o_chan = prod_sat[14:7];
                end
                MODE_OFFSET: begin
                    if (sum < 0) begin
                        o_chan = 8'd0;
                    end else if (sum > $signed({2'b00, CHAN_MAX})) begin
                        o_chan = CHAN_MAX;
                    end else begin
                        o_chan = sum[7:0];
                    end
                end
                MODE_FILL: begin
                    o_chan = i_cfg.fill;
                end
                default: begin
                    o_chan = i_chan;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/palette_color_adjust.sv
// Top level of the palette color adjust block: configuration registers,
// two-stage stream pipeline, save buffer and three channel units.
// Uses pca_pkg, pca_save_mem and pca_chan_alu.
//
// Usage:
//   Input stream s_axis_*: one palette entry per request, tdata holds red,
//   green, blue, spare and entry index, tlast the table's last mark.
//   Output stream m_axis_*: one adjusted entry per input request, tdata
//   holds red, green, blue and spare, tlast copies the input mark.
//   Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data;
//   write only while no request is in flight.
//   Path: the accepting edge loads the middle stage and reads the buffer;
//   channel arithmetic on the middle stage feeds the output register.
//   Throughput: one entry per cycle without stalls; the save buffer takes
//   one write or one read per request, and a mode never both saves and
//   restores, so neighboring requests never contend for the same entry.
//   Reset empties the pipeline and loads the register defaults; the save
//   buffer is not cleared, restore of an unsaved index returns garbage.
//   When the receiver stalls, the output register holds its entry and one
//   more entry waits in the middle stage; s_axis_tready drops only when
//   both are full.
`default_nettype none

module palette_color_adjust #(
    parameter int SAVE_DEPTH = pca_pkg::PCA_SAVE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // red, green, blue, spare, entry_index
    input  wire logic        s_axis_tlast,  // last_in
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // red_out, green_out, blue_out, spare_out
    output logic             m_axis_tlast   // last_out
);
    import pca_pkg::*;

    localparam int AW = (SAVE_DEPTH > 1) ? $clog2(SAVE_DEPTH) : 1;

    // Configuration registers
    logic [2:0]        r_mode;
    logic [15:0]       r_scale;
    logic signed [8:0] r_red_off;
    logic signed [8:0] r_green_off;
    logic signed [8:0] r_blue_off;
    logic [7:0]        r_fill_red;
    logic [7:0]        r_fill_green;
    logic [7:0]        r_fill_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SCALE;
            r_scale      <= SCALE_RESET;
            r_red_off    <= '0;
            r_green_off  <= '0;
            r_blue_off   <= '0;
            r_fill_red   <= '0;
            r_fill_green <= '0;
            r_fill_blue  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:         r_mode       <= i_cfg_data[2:0];
                CFG_SCALE_FACTOR: r_scale      <= i_cfg_data;
                CFG_RED_OFFSET:   r_red_off    <= i_cfg_data[8:0];
                CFG_GREEN_OFFSET: r_green_off  <= i_cfg_data[8:0];
                CFG_BLUE_OFFSET:  r_blue_off   <= i_cfg_data[8:0];
                CFG_FILL_RED:     r_fill_red   <= i_cfg_data[7:0];
                CFG_FILL_GREEN:   r_fill_green <= i_cfg_data[7:0];
                CFG_FILL_BLUE:    r_fill_blue  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Handshake: middle stage moves when the output register is free
    logic in_acc;
    logic out_free;
    logic r_s1_valid;
    logic r_out_valid;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Entry index reduced modulo the buffer depth (restoring steps)
    function automatic logic [7:0] f_reduce(input logic [7:0] v);
        logic [16:0] x;
        logic [16:0] d;
        x = {9'd0, v};
        for (int k = 7; k >= 0; k--) begin
            d = 17'(SAVE_DEPTH) << k;
            if (x >= d) begin
                x = x - d;
            end
        end
        return x[7:0];
    endfunction

    logic [AW-1:0] mem_addr;

    generate
        if (SAVE_DEPTH >= 256) begin : g_idx_wide
            assign mem_addr = AW'(s_axis_tdata[39:32]);
        end else begin : g_idx_mod
            assign mem_addr = AW'(f_reduce(s_axis_tdata[39:32]));
        end
    endgenerate

    // Save buffer: write on save, read on restore
    logic [31:0] mem_rdata;

    pca_save_mem #(
        .DEPTH (SAVE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (in_acc && (r_mode == MODE_SAVE)),
        .i_waddr (mem_addr),
        .i_wdata (s_axis_tdata[31:0]),
        .i_re    (in_acc && (r_mode == MODE_RESTORE)),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    // Middle stage: entry waits here while the buffer read completes
    logic [31:0] r_s1_data;
    logic        r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_data <= s_axis_tdata[31:0];
            r_s1_last <= s_axis_tlast;
        end
    end

    // Channel units
    logic      alu_en;
    t_chan_cfg cfg_r;
    t_chan_cfg cfg_g;
    t_chan_cfg cfg_b;
    logic [7:0] red_adj;
    logic [7:0] green_adj;
    logic [7:0] blue_adj;

    assign alu_en = (r_mode != MODE_RESTORE);
    assign cfg_r  = '{mode: r_mode, scale: r_scale, offset: r_red_off,   fill: r_fill_red};
    assign cfg_g  = '{mode: r_mode, scale: r_scale, offset: r_green_off, fill: r_fill_green};
    assign cfg_b  = '{mode: r_mode, scale: r_scale, offset: r_blue_off,  fill: r_fill_blue};

    pca_chan_alu u_alu_red (
        .i_en   (alu_en),
        .i_chan (r_s1_data[7:0]),
        .i_cfg  (cfg_r),
        .o_chan (red_adj)
    );

    pca_chan_alu u_alu_green (
        .i_en   (alu_en),
        .i_chan (r_s1_data[15:8]),
        .i_cfg  (cfg_g),
        .o_chan (green_adj)
    );

    pca_chan_alu u_alu_blue (
        .i_en   (alu_en),
        .i_chan (r_s1_data[23:16]),
        .i_cfg  (cfg_b),
        .o_chan (blue_adj)
    );

    // Result select: restore takes the stored word whole
    logic [31:0] n_out_data;

    always_comb begin
        if (r_mode == MODE_RESTORE) begin
            n_out_data = mem_rdata;
        end else begin
            n_out_data = {r_s1_data[31:24], blue_adj, green_adj, red_adj};
        end
    end

    // Output register
    logic [31:0] r_out_data;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### sv/pca_checker.sv
// Port-level checks for the palette color adjust block, bound to the top.
// Depends on the palette_color_adjust port list only.
`default_nettype none

module pca_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // Reset empties the pipeline and opens the input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    // With an empty output register the block always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output register empty");

    // While the output drains, the input is ready
    a_ready_when_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |-> s_axis_tready)
        else $error("input blocked while output drains");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

endmodule

bind palette_color_adjust pca_checker u_pca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
